>>> rtl/core/fnts_pkg.sv
// Shared widths, constants and beat types of the fold-normalized trace stack.
package fnts_pkg;

  // Field widths
  localparam int SAMPLE_W = 32;
  localparam int INDEX_W  = 11;
  localparam int FOLD_W   = 9;
  localparam int TRACE_W  = 9;
  localparam int SUM_W    = 40;

  // Stream widths; the tdata widths are padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 64;

  // Bit positions of the input flags in in_tuser
  localparam int TUSER_FIRST = 0;
  localparam int TUSER_LAST  = 1;

  // One store word holds the running sum above the fold
  localparam int RAM_W = SUM_W + FOLD_W;

  // Trace counter limit
  localparam int MAX_TRACES_PER_BIN = 256;

  // Saturation limits
  localparam logic [FOLD_W-1:0]   FOLD_MAX = {FOLD_W{1'b1}};
  localparam logic [SUM_W-1:0]    SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]    SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] OUT_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] OUT_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  // Largest quotient magnitudes that still fit the output, per sign
  localparam logic [SUM_W-1:0]    QPOS_LIM = {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]    QNEG_LIM = {{(SUM_W-SAMPLE_W){1'b0}}, 1'b1,
                                              {(SAMPLE_W-1){1'b0}}};

  // Divider: quotient bits resolved per pipeline stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = SUM_W / DIV_BITS;

  // Accumulated sample handed from the store to the divider
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [FOLD_W-1:0]  fold;
    logic [INDEX_W-1:0] idx;
    logic [TRACE_W-1:0] traces;
  } acc_item_t;

  // One stage of the restoring divider
  typedef struct packed {
    logic               neg;
    logic [FOLD_W-1:0]  fold;
    logic [FOLD_W-1:0]  rem;
    logic [SUM_W-1:0]   dq;
    logic [INDEX_W-1:0] idx;
    logic [TRACE_W-1:0] traces;
  } div_stage_t;

endpackage

>>> rtl/core/fnts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fnts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/fnts_accum.sv
// Sum and fold store: read-modify-write per sample with write forwarding, trace counter.
module fnts_accum #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fnts_pkg::SAMPLE_W-1:0] in_value,
  input  logic [fnts_pkg::INDEX_W-1:0] in_index,
  input  logic                         in_first,
  input  logic                         in_last,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output fnts_pkg::acc_item_t          dn_item
);
  import fnts_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic                 accept;
  logic [AW-1:0]        rd_addr;
  logic [RAM_W-1:0]     rd_word;
  logic                 in_range;
  logic [TRACE_W-1:0]   traces_r;
  logic [TRACE_W-1:0]   traces_nxt;

  logic                 s1_valid_r;
  logic [SAMPLE_W-1:0]  s1_value_r;
  logic [INDEX_W-1:0]   s1_idx_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_first_r;
  logic                 s1_last_r;
  logic                 s1_range_r;
  logic [TRACE_W-1:0]   s1_traces_r;
  logic                 s1_emit;
  logic                 s1_adv;

  logic                 fwd_r;
  logic [RAM_W-1:0]     fwd_word_r;

  logic [RAM_W-1:0]     old_word;
  logic [SUM_W-1:0]     old_sum;
  logic [FOLD_W-1:0]    old_fold;
  logic [SUM_W:0]       sum_ext;
  logic [FOLD_W:0]      fold_ext;
  logic                 nz;
  logic [SUM_W-1:0]     new_sum;
  logic [FOLD_W-1:0]    new_fold;
  logic                 wr_en;
  logic [RAM_W-1:0]     wr_word;

  // Handshake: S1 frees up when its sample leaves or drops out
  assign s1_emit  = s1_last_r && s1_range_r;
  assign s1_adv   = s1_valid_r && (!s1_emit || dn_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  assign rd_addr  = AW'(in_index);
  assign in_range = (32'(in_index) < 32'(MAX_SAMPLES));

  // Count traces: first trace restarts, index zero opens the next one
  always_comb begin
    traces_nxt = traces_r;
    if (in_first) begin
      traces_nxt = TRACE_W'(1);
    end else if (in_index == '0 && traces_r < TRACE_W'(MAX_TRACES_PER_BIN)) begin
      traces_nxt = traces_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      traces_r <= '0;
    end else if (accept) begin
      traces_r <= traces_nxt;
    end
  end

  // Load S1 on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r  <= in_value;
      s1_idx_r    <= in_index;
      s1_addr_r   <= rd_addr;
      s1_first_r  <= in_first;
      s1_last_r   <= in_last;
      s1_range_r  <= in_range;
      s1_traces_r <= traces_nxt;
    end
  end

  // Forward the write that lands in the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (accept) begin
      fwd_r <= wr_en && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_word_r <= wr_word;
    end
  end

  // Modify: overwrite on the first trace, saturating add otherwise
  always_comb begin
    old_word = fwd_r ? fwd_word_r : rd_word;
    old_sum  = old_word[RAM_W-1:FOLD_W];
    old_fold = old_word[FOLD_W-1:0];
    nz       = |s1_value_r;
    sum_ext  = {old_sum[SUM_W-1], old_sum}
             + {{(SUM_W-SAMPLE_W+1){s1_value_r[SAMPLE_W-1]}}, s1_value_r};
    fold_ext = {1'b0, old_fold} + (FOLD_W+1)'(nz);
    if (s1_first_r) begin
      new_sum  = {{(SUM_W-SAMPLE_W){s1_value_r[SAMPLE_W-1]}}, s1_value_r};
      new_fold = FOLD_W'(nz);
    end else begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
        new_sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
        new_sum = sum_ext[SUM_W-1:0];
      end
      new_fold = fold_ext[FOLD_W] ? FOLD_MAX : fold_ext[FOLD_W-1:0];
    end
  end

  // Write back as the sample leaves S1
  assign wr_en   = s1_adv && s1_range_r;
  assign wr_word = {new_sum, new_fold};

  fnts_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_word),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // Hand last-trace samples to the divider
  assign dn_valid       = s1_valid_r && s1_emit;
  assign dn_item.sum    = new_sum;
  assign dn_item.fold   = new_fold;
  assign dn_item.idx    = s1_idx_r;
  assign dn_item.traces = s1_traces_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && s1_emit && !dn_ready)
    else $error("input stalled without a blocked result in S1");

  a_trace_cap: assert property (@(posedge clk) disable iff (!rst_n)
    traces_r <= TRACE_W'(MAX_TRACES_PER_BIN))
    else $error("trace count beyond its limit");

  a_first_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_first |=> traces_r == TRACE_W'(1) && s1_traces_r == TRACE_W'(1))
    else $error("first trace did not restart the trace count");

endmodule

>>> rtl/core/fnts_div.sv
// Pipelined restoring divider: stacked sum by fold, sign-magnitude, a few bits per stage.
module fnts_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  fnts_pkg::acc_item_t  up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output fnts_pkg::div_stage_t dn_stage
);
  import fnts_pkg::*;

  div_stage_t              stg_r [DIV_STAGES+1];
  logic [DIV_STAGES:0]     vld_r;
  logic [DIV_STAGES+1:0]   rdy;
  div_stage_t              stg_in;

  // Ready ripples back: a stage takes data if empty or draining
  assign rdy[DIV_STAGES+1] = dn_ready;
  assign up_ready          = rdy[0];

  // Entry: split sign and magnitude
  always_comb begin
    stg_in.neg    = up_item.sum[SUM_W-1];
    stg_in.fold   = up_item.fold;
    stg_in.rem    = '0;
    stg_in.dq     = up_item.sum[SUM_W-1] ? (~up_item.sum + 1'b1) : up_item.sum;
    stg_in.idx    = up_item.idx;
    stg_in.traces = up_item.traces;
  end

  for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_stage
    div_stage_t        st_c;
    logic [FOLD_W:0]   part_c;
    logic              qbit_c;
    logic              vld_in;

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    if (k == 0) begin : g_entry
      assign st_c   = stg_in;
      assign vld_in = up_valid;
      assign part_c = '0;
      assign qbit_c = 1'b0;
    end else begin : g_step
      // Resolve DIV_BITS quotient bits, shifting dividend out and quotient in
      always_comb begin
        st_c   = stg_r[k-1];
        part_c = '0;
        qbit_c = 1'b0;
        for (int b = 0; b < DIV_BITS; b++) begin
          part_c = {st_c.rem, st_c.dq[SUM_W-1]};
          qbit_c = (part_c >= {1'b0, st_c.fold});
          if (qbit_c) begin
            st_c.rem = FOLD_W'(part_c - {1'b0, st_c.fold});
          end else begin
            st_c.rem = part_c[FOLD_W-1:0];
          end
          st_c.dq = {st_c.dq[SUM_W-2:0], qbit_c};
        end
      end
      assign vld_in = vld_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        stg_r[k] <= st_c;
      end
    end
  end

  assign dn_valid = vld_r[DIV_STAGES];
  assign dn_stage = stg_r[DIV_STAGES];

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid && dn_stage.fold != '0 |-> dn_stage.rem < dn_stage.fold)
    else $error("divider remainder not below the fold");

endmodule

>>> rtl/core/fold_normalized_trace_stack_core.sv
// Top level of the fold-normalized trace stack: stream ports, store, divider, output register.
//
// Stacks the traces of one bin sample by sample. Each input beat carries one
// Q16.16 sample, its index and first/last-trace flags; the block keeps a
// 40-bit running sum and a 9-bit fold per index in one RAM word. Samples of
// the first trace overwrite the entry, so the store needs no clearing pass
// and is ready right after reset. Every in-range sample of the last trace of
// a bin yields one output beat: sum/fold truncated toward zero and saturated
// to 32 bits (zero for a fold of zero), with the index, the fold and the
// trace count. One beat is taken per clock while the output is not
// back-pressured, with any index order: the sum/fold RAM is read on accept
// and written as the sample leaves S1, and a write that meets a read of the
// same entry in one edge is forwarded. Between input beat and output beat
// lie the S1 register of the store read-modify-write, the divider stages
// (four quotient bits a step stage) and the output register.
module fold_normalized_trace_stack_core #(
  parameter int MAX_SAMPLES = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_value[31:0], sample_index[42:32], zero fill
  input  logic [fnts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // first_trace[0], last_trace[1]
  input  logic [fnts_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // stacked_value[31:0], out_index[42:32], fold_count[51:43], trace_count[60:52], zero fill
  output logic [fnts_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fnts_pkg::*;

  logic                  acc_valid;
  logic                  acc_ready;
  acc_item_t             acc_item;
  logic                  div_valid;
  logic                  div_ready;
  div_stage_t            div_stage;
  logic [SAMPLE_W-1:0]   stacked;
  logic                  out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  fnts_accum #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[SAMPLE_W-1:0]),
    .in_index (in_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W]),
    .in_first (in_tuser[TUSER_FIRST]),
    .in_last  (in_tuser[TUSER_LAST]),
    .dn_valid (acc_valid),
    .dn_ready (acc_ready),
    .dn_item  (acc_item)
  );

  fnts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (acc_valid),
    .up_ready (acc_ready),
    .up_item  (acc_item),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_stage (div_stage)
  );

  // Apply sign and saturate the quotient to 32 bits
  always_comb begin
    if (div_stage.fold == '0) begin
      stacked = '0;
    end else if (div_stage.neg) begin
      if (div_stage.dq > QNEG_LIM) begin
        stacked = OUT_MIN;
      end else begin
        stacked = SAMPLE_W'(~div_stage.dq + 1'b1);
      end
    end else begin
      if (div_stage.dq > QPOS_LIM) begin
        stacked = OUT_MAX;
      end else begin
        stacked = div_stage.dq[SAMPLE_W-1:0];
      end
    end
  end

  // Output register: load when empty or the current beat is taken
  assign div_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (div_ready) begin
      out_tvalid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) begin
      out_tdata_r <= OUT_TDATA_W'({div_stage.traces, div_stage.fold, div_stage.idx, stacked});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_zero_fold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SAMPLE_W+INDEX_W+FOLD_W-1:SAMPLE_W+INDEX_W] == '0
      |-> out_tdata[SAMPLE_W-1:0] == '0)
    else $error("nonzero stacked value with a fold of zero");

endmodule
